// File: sv/pvg_pkg.sv
// Shared types, codes and format helpers for the PCM volume gain block.
package pvg_pkg;

	typedef enum logic [1:0] {
		FMT_INT16   = 2'd0,
		FMT_INT24   = 2'd1,
		FMT_INT32   = 2'd2,
		FMT_FLOAT32 = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_MUTE  = 2'd1,
		MODE_SCALE = 2'd2
	} mode_t;

	// register indexes on the config port
	localparam logic [1:0] CFG_GAIN   = 2'd0;
	localparam logic [1:0] CFG_FORMAT = 2'd1;

	localparam logic [16:0] GAIN_RESET = 17'd65536;
	localparam logic [16:0] UNITY_MIN  = 17'd65504;
	localparam logic [16:0] MUTE_MAX   = 17'd32;

	// input register contents
	typedef struct packed {
		logic        valid;
		logic        last;
		mode_t       mode;
		fmt_t        fmt;
		logic [31:0] word;
		logic [15:0] gain;
		logic [3:0]  lg;    // position of the gain's leading one
	} s1_t;

	// product register contents
	typedef struct packed {
		logic        valid;
		logic        last;
		mode_t       mode;
		fmt_t        fmt;
		logic [31:0] word;
		logic        neg;
		logic [47:0] prod;
		logic [3:0]  lg;
	} s2_t;

	function automatic logic [31:0] fmt_mask(input fmt_t fmt);
		case (fmt)
			FMT_INT16: return 32'h0000_FFFF;
			FMT_INT24: return 32'h00FF_FFFF;
			default:   return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] fmt_sign(input fmt_t fmt);
		case (fmt)
			FMT_INT16: return 32'h0000_8000;
			FMT_INT24: return 32'h0080_0000;
			default:   return 32'h8000_0000;
		endcase
	endfunction

endpackage

// File: sv/pvg_mul.sv
// Sample decode and gain multiply, ending in the product register.
module pvg_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  pvg_pkg::s1_t  s1,
	output pvg_pkg::s2_t  s2
);

	logic [31:0] mask;
	logic [31:0] sbit;
	logic [31:0] raw;
	logic        neg;
	logic [31:0] mag;
	logic [31:0] opa;
	logic [47:0] prod;

	always_comb begin
		mask = pvg_pkg::fmt_mask(s1.fmt);
		sbit = pvg_pkg::fmt_sign(s1.fmt);
		raw  = s1.word & mask;
		neg  = (s1.fmt != pvg_pkg::FMT_FLOAT32) && ((raw & sbit) != 32'd0);
		mag  = neg ? ((~raw + 32'd1) & mask) : raw;
		if (s1.fmt == pvg_pkg::FMT_FLOAT32) begin
			// significand with hidden bit, none for subnormals
			opa = {8'd0, (s1.word[30:23] != 8'd0), s1.word[22:0]};
		end else begin
			opa = mag;
		end
		prod = opa * s1.gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else begin
			s2.valid <= s1.valid;
			s2.last  <= s1.last;
			s2.mode  <= s1.mode;
			s2.fmt   <= s1.fmt;
			s2.word  <= s1.word;
			s2.neg   <= neg;
			s2.prod  <= prod;
			s2.lg    <= s1.lg;
		end
	end

endmodule

// File: sv/pvg_round.sv
// Rounding, saturation and float repacking, ending in the result register.
module pvg_round (
	input  logic          clk,
	input  logic          arst_n,
	input  pvg_pkg::s2_t  s2,
	output logic          done,
	output logic [31:0]   scaled_word,
	output logic          last_out
);

	function automatic logic [40:0] round_even(input logic [39:0] p, input logic [4:0] sh);
		logic [39:0] q;
		logic [39:0] rem;
		logic [39:0] half;
		q    = p >> sh;
		rem  = p & ((40'd1 << sh) - 40'd1);
		half = (sh == 5'd0) ? 40'd0 : (40'd1 << (sh - 5'd1));
		if (sh == 5'd0) begin
			return {1'b0, p};
		end
		if ((rem > half) || ((rem == half) && q[0])) begin
			return {1'b0, q} + 41'd1;
		end
		return {1'b0, q};
	endfunction

	logic [31:0]        mask;
	logic [31:0]        sbit;
	// integer path
	logic [47:0]        isum;
	logic [31:0]        qi;
	logic [31:0]        lim;
	logic [31:0]        sat;
	logic [31:0]        ires;
	// float path
	logic               fs;
	logic [7:0]         fe;
	logic               is_sub;
	logic [7:0]         expo;
	logic [39:0]        p;
	logic [5:0]         cidx;
	logic               carry;
	logic signed [9:0]  re;
	logic signed [9:0]  re2;
	logic               norm;
	logic [4:0]         sh;
	logic [40:0]        q;
	logic [23:0]        qn;
	logic [23:0]        qc;
	logic [31:0]        fres;
	logic [31:0]        res;

	pvg_pkg::fmt_t      fmt_s3;

	always_comb begin
		mask = pvg_pkg::fmt_mask(s2.fmt);
		sbit = pvg_pkg::fmt_sign(s2.fmt);

		// round half away from zero on the magnitude, then clamp
		isum = s2.prod + 48'd32768;
		qi   = isum[47:16];
		lim  = s2.neg ? sbit : (sbit - 32'd1);
		sat  = (qi > lim) ? lim : qi;
		ires = (s2.neg ? (~sat + 32'd1) : sat) & mask;

		fs     = s2.word[31];
		fe     = s2.word[30:23];
		is_sub = (fe == 8'd0);
		expo   = is_sub ? 8'd1 : fe;
		p      = s2.prod[39:0];
		// normal input: product top bit is at 23+lg or one above
		cidx   = {2'd0, s2.lg} + 6'd24;
		carry  = p[cidx];
		re     = $signed({6'd0, s2.lg}) + $signed({9'd0, carry})
		       + $signed({2'd0, expo}) - 10'sd16;
		norm   = !is_sub && (re >= 10'sd1);
		sh     = norm ? ({1'b0, s2.lg} + {4'd0, carry}) : (5'd17 - expo[4:0]);
		q      = round_even(p, sh);
		if (q[24]) begin
			qn  = q[24:1];
			re2 = re + 10'sd1;
		end else begin
			qn  = q[23:0];
			re2 = re;
		end
		qc = (q > 41'h80_0000) ? 24'h80_0000 : q[23:0];

		if (fe == 8'hFF) begin
			fres = s2.word;                       // NaN and infinity pass
		end else if (norm) begin
			if (re2 > 10'sd254) begin
				fres = {fs, 8'hFF, 23'd0};
			end else begin
				fres = {fs, re2[7:0], qn[22:0]};
			end
		end else begin
			fres = {fs, 7'd0, qc};                // subnormal or zero result
		end

		case (s2.mode)
			pvg_pkg::MODE_PASS:  res = s2.word & mask;
			pvg_pkg::MODE_MUTE:  res = 32'd0;
			pvg_pkg::MODE_SCALE: res = (s2.fmt == pvg_pkg::FMT_FLOAT32) ? fres : ires;
			default:             res = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		scaled_word <= res;
		last_out    <= s2.last;
		fmt_s3      <= s2.fmt;
	end

	a_mute_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s2.valid && s2.mode == pvg_pkg::MODE_MUTE |=> done && scaled_word == 32'd0)
		else $error("muted request gave a nonzero word");

	a_int16_high_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && fmt_s3 == pvg_pkg::FMT_INT16 |-> scaled_word[31:16] == 16'd0)
		else $error("int16 result has high bits set");

	a_int24_high_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && fmt_s3 == pvg_pkg::FMT_INT24 |-> scaled_word[31:24] == 8'd0)
		else $error("int24 result has high bits set");

endmodule

// File: sv/pcm_volume_gain.sv
// Top level of the PCM volume gain: config registers, input register, pipeline.
//
//   channel   signals                                  direction  handshake
//   ------------------------------------------------------------------------------
//   request   start, busy, sample_word, last_of_block   in         start && !busy
//   result    done, scaled_word, last_out               out        done strobe, 1 cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// Three register stages: input, product, result; done is set with the result register.
// busy stays low: the pipeline takes a request every cycle, one result per cycle.
// The receiver cannot stall, so nothing in the pipe ever holds.
// Reset (arst_n low) clears the input and product registers and done, and loads
// gain 65536, format int16. The user must write config only while the pipe is
// empty; the block itself does not enforce it.
module pcm_volume_gain (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample_word,
	input  logic        last_of_block,
	// result
	output logic        done,
	output logic [31:0] scaled_word,
	output logic        last_out,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	// leading-one position of a gain word
	function automatic logic [3:0] lead_one(input logic [15:0] g);
		logic [3:0] pos;
		pos = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (g[i]) begin
				pos = 4'(i);
			end
		end
		return pos;
	endfunction

	logic [16:0]       gain_q;
	pvg_pkg::fmt_t     fmt_q;
	pvg_pkg::mode_t    mode;
	logic              accept;
	pvg_pkg::s1_t      s1;
	pvg_pkg::s2_t      s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// config registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= pvg_pkg::GAIN_RESET;
			fmt_q  <= pvg_pkg::FMT_INT16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pvg_pkg::CFG_GAIN:   gain_q <= cfg_data;
				pvg_pkg::CFG_FORMAT: fmt_q  <= pvg_pkg::fmt_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// unity wins over mute, scaling only in between
	always_comb begin
		if (gain_q >= pvg_pkg::UNITY_MIN) begin
			mode = pvg_pkg::MODE_PASS;
		end else if (gain_q <= pvg_pkg::MUTE_MAX) begin
			mode = pvg_pkg::MODE_MUTE;
		end else begin
			mode = pvg_pkg::MODE_SCALE;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else begin
			s1.valid <= accept;
			s1.last  <= last_of_block;
			s1.mode  <= mode;
			s1.fmt   <= fmt_q;
			s1.word  <= sample_word;
			s1.gain  <= gain_q[15:0];
			s1.lg    <= lead_one(gain_q[15:0]);
		end
	end

	pvg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.s2     (s2)
	);

	pvg_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.s2          (s2),
		.done        (done),
		.scaled_word (scaled_word),
		.last_out    (last_out)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("request did not reach the result strobe in three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(s1.valid, 2))
		else $error("result strobe without a matching request");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the PCM volume gain block: predictor, driver and monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Index with no register behind it: the write must be dropped.
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;

	// How the driver spaces its requests
	typedef enum logic [1:0] {
		PACE_FULL,   // back to back
		PACE_LIGHT,  // mostly back to back, an odd gap
		PACE_HEAVY   // a random gap, possibly none, before every request
	} pace_t;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} sample_req_t;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} scaled_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] sample_word = '0;
	logic        last_of_block = 1'b0;
	logic        done;
	logic [31:0] scaled_word;
	logic        last_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;

	// Our own copy of the two registers, updated on each accepted write
	logic [16:0]   model_gain = pvg_pkg::GAIN_RESET;
	pvg_pkg::fmt_t model_fmt = pvg_pkg::FMT_INT16;

	sample_req_t sample_reqs[$];    // requests waiting for the driver
	scaled_rec_t scaled_expect[$];  // predicted results, oldest first
	pace_t       pace = PACE_FULL;
	int unsigned idle_left = 0;
	int unsigned mismatch_cnt = 0;
	sample_req_t cur_req;
	scaled_rec_t pred_rec;
	scaled_rec_t exp_rec;

	pcm_volume_gain dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample_word   (sample_word),
		.last_of_block (last_of_block),
		.done          (done),
		.scaled_word   (scaled_word),
		.last_out      (last_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Shift right by sh with round to nearest, ties to even.
	function automatic logic [63:0] round_nearest_even(input logic [63:0] p, input int sh);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		if (sh <= 0) return p;
		if (sh > 62) return 64'd0;
		q = p >> sh;
		rem = p & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q;
	endfunction

	// Integer formats: sign/magnitude multiply, round half away from zero,
	// clamp to the signed range of the format.
	function automatic logic [31:0] scale_pcm_int(input logic [31:0] w, input logic [16:0] g,
			input int bits);
		logic [31:0] mask;
		logic [31:0] sgn;
		logic [31:0] raw;
		logic [31:0] r;
		logic        neg;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] lim;
		mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
		sgn = 32'd1 << (bits - 1);
		raw = w & mask;
		neg = (raw & sgn) != 32'd0;
		mag = neg ? {32'd0, (~raw + 32'd1) & mask} : {32'd0, raw};
		if (neg && mag == 64'd0) mag = {32'd0, sgn};
		q = (mag * {47'd0, g} + 64'd32768) >> 16;
		lim = neg ? {32'd0, sgn} : {32'd0, sgn - 32'd1};
		if (q > lim) q = lim;
		r = q[31:0];
		if (neg) r = ~r + 32'd1;
		return r & mask;
	endfunction

	// Float32: exact product of significand and gain, one rounding at the end.
	// NaN/inf pass, zero keeps its sign, subnormals underflow gradually.
	function automatic logic [31:0] scale_pcm_float(input logic [31:0] w, input logic [16:0] g);
		logic [31:0] s;
		logic [7:0]  e;
		logic [63:0] mant;
		logic [63:0] p;
		logic [63:0] q;
		int          ex;
		int          msb;
		int          re;
		s = {w[31], 31'd0};
		e = w[30:23];
		if (e == 8'hFF) return w;
		mant = (e == 8'd0) ? {41'd0, w[22:0]} : {40'd0, 1'b1, w[22:0]};
		ex = (e == 8'd0) ? 1 : int'(e);
		p = mant * {47'd0, g};   // value = p * 2^(ex-166)
		if (p == 64'd0) return s;
		msb = 0;
		for (int i = 0; i < 64; i++) if (p[i]) msb = i;
		re = msb + ex - 39;
		if (re >= 1) begin
			q = round_nearest_even(p, msb - 23);
			if (q >= (64'd1 << 24)) begin
				q = q >> 1;
				re++;
			end
			if (re > 254) return s | 32'h7F80_0000;
			return {w[31], 8'(re), q[22:0]};
		end
		q = round_nearest_even(p, 17 - ex);
		if (q > 64'h80_0000) q = 64'h80_0000;
		return s | q[31:0];
	endfunction

	function automatic logic [31:0] predict_scaled(input logic [31:0] w, input logic [16:0] g,
			input pvg_pkg::fmt_t f);
		int          bits;
		logic [31:0] mask;
		bits = (f == pvg_pkg::FMT_INT16) ? 16 : (f == pvg_pkg::FMT_INT24) ? 24 : 32;
		mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
		if (g >= pvg_pkg::UNITY_MIN) return w & mask;   // near unity: plain pass
		if (g <= pvg_pkg::MUTE_MAX) return 32'd0;       // near zero: mute, NaN too
		if (f == pvg_pkg::FMT_FLOAT32) return scale_pcm_float(w, g);
		return scale_pcm_int(w, g, bits);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued requests, draws a gap after each one.
	// A request is taken at an edge with start high and busy low; its
	// result is predicted right there, with the registers as they stand.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				pred_rec.word = predict_scaled(sample_word, model_gain, model_fmt);
				pred_rec.last = last_of_block;
				scaled_expect.push_back(pred_rec);
			end
			if (start && busy) begin
				// not taken yet: hold the request as it is
			end else if (idle_left != 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (sample_reqs.size() != 0) begin
				cur_req = sample_reqs.pop_front();
				start <= 1'b1;
				sample_word <= cur_req.word;
				last_of_block <= cur_req.last;
				case (pace)
					PACE_FULL:  idle_left = 0;
					PACE_LIGHT: idle_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
					default:    idle_left = $urandom_range(0, 15);
				endcase
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every done strobe is matched against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (scaled_expect.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%t: result with none pending: scaled_word=%h last_out=%b",
						$realtime, scaled_word, last_out);
			end else begin
				exp_rec = scaled_expect.pop_front();
				if (scaled_word !== exp_rec.word) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%t: scaled_word expected %h got %h", $realtime,
							exp_rec.word, scaled_word);
				end
				if (last_out !== exp_rec.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%t: last_out expected %b got %b", $realtime,
							exp_rec.last, last_out);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Checked at the falling edge, when driver and monitor have settled.
	task automatic wait_idle();
		do @(negedge clk); while (sample_reqs.size() != 0 || start || scaled_expect.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pvg_pkg::CFG_GAIN:   model_gain = data;
			pvg_pkg::CFG_FORMAT: model_fmt = pvg_pkg::fmt_t'(data[1:0]);
			default:             ;   // unmapped index: dropped
		endcase
	endtask

	// Pipe must be drained before the registers change. Every request
	// yields a result, so an empty prediction queue means an empty pipe.
	// Spare bits of the format write carry noise.
	task automatic set_config(input logic [16:0] g, input pvg_pkg::fmt_t f);
		wait_idle();
		write_reg(pvg_pkg::CFG_GAIN, g);
		write_reg(pvg_pkg::CFG_FORMAT, {15'($urandom), f});
	endtask

	task automatic queue_sample(input logic [31:0] w, input logic last);
		sample_req_t r;
		r.word = w;
		r.last = last;
		sample_reqs.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		pvg_pkg::fmt_t f;
		logic [16:0]   g;
		logic [31:0]   fmask;
		logic [31:0]   fsign;
		logic [31:0]   w;
		logic [31:0]   v;
		int unsigned   n;
		int unsigned   random_items;
		logic [16:0]   gain_edges[8];

		gain_edges = '{17'd0, 17'd32, 17'd33, 17'd65503, 17'd65504, 17'd65535,
			17'd65536, 17'd131071};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: unity gain, int16 -> pass, high bits dropped
		pace = PACE_FULL;
		queue_sample(32'hDEAD_8000, 1'b1);
		queue_sample(32'h1234_7FFF, 1'b0);

		// Mute, including NaN; a write to an unmapped index must not land
		set_config(17'd0, pvg_pkg::FMT_FLOAT32);
		write_reg(CFG_UNMAPPED, 17'h1FFFF);
		queue_sample(32'h7FC0_0000, 1'b1);
		set_config(pvg_pkg::MUTE_MAX, pvg_pkg::FMT_FLOAT32);
		queue_sample(32'hFFFF_FFFF, 1'b0);

		// Smallest scaling gain, int16 extremes with junk high bits
		pace = PACE_HEAVY;
		set_config(17'd33, pvg_pkg::FMT_INT16);
		queue_sample(32'hFFFF_8000, 1'b1);
		queue_sample(32'h0000_7FFF, 1'b0);
		queue_sample(32'hABCD_FFFF, 1'b1);
		queue_sample(32'h0000_0001, 1'b0);

		// Largest scaling gain, int24 and int32 extremes
		set_config(17'd65503, pvg_pkg::FMT_INT24);
		queue_sample(32'hFF80_0000, 1'b0);
		queue_sample(32'h007F_FFFF, 1'b1);
		queue_sample(32'h00FF_FFFF, 1'b0);
		set_config(17'd65503, pvg_pkg::FMT_INT32);
		queue_sample(32'h8000_0000, 1'b1);
		queue_sample(32'h7FFF_FFFF, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b1);
		queue_sample(32'h0000_0000, 1'b0);

		// Float: infinities, NaN with payload, signed zero, subnormals,
		// largest finite, smallest normal
		pace = PACE_LIGHT;
		set_config(17'd40000, pvg_pkg::FMT_FLOAT32);
		queue_sample(32'h7F80_0000, 1'b0);
		queue_sample(32'hFF80_0000, 1'b1);
		queue_sample(32'hFFC0_0001, 1'b0);
		queue_sample(32'h8000_0000, 1'b1);
		queue_sample(32'h0000_0001, 1'b0);
		queue_sample(32'h807F_FFFF, 1'b1);
		queue_sample(32'h7F7F_FFFF, 1'b0);
		queue_sample(32'h0080_0000, 1'b1);

		// Gain above unity and at the unity threshold
		set_config(17'd131071, pvg_pkg::FMT_INT32);
		queue_sample(32'h8000_0001, 1'b1);
		set_config(pvg_pkg::UNITY_MIN, pvg_pkg::FMT_INT24);
		queue_sample(32'hFF80_0001, 1'b0);

		// Random phases: new gain/format/pace each, mostly in the scaling range
		random_items = 0;
		while (random_items < 1750) begin
			case ($urandom_range(0, 9))
				0:       g = gain_edges[$urandom_range(0, 7)];
				1:       g = 17'($urandom);
				2:       g = 17'($urandom_range(33, 1000));
				default: g = 17'($urandom_range(33, 65503));
			endcase
			f = pvg_pkg::fmt_t'($urandom_range(0, 3));
			pace = pace_t'($urandom_range(0, 2));
			set_config(g, f);
			fmask = (f == pvg_pkg::FMT_INT16) ? 32'h0000_FFFF :
				(f == pvg_pkg::FMT_INT24) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
			fsign = (f == pvg_pkg::FMT_INT16) ? 32'h0000_8000 :
				(f == pvg_pkg::FMT_INT24) ? 32'h0080_0000 : 32'h8000_0000;
			n = $urandom_range(10, 80);
			repeat (n) begin
				w = $urandom;
				case ($urandom_range(0, 7))
					0: begin
						if (f == pvg_pkg::FMT_FLOAT32) begin
							// exponent edges: zero/subnormal, smallest, inf/NaN,
							// largest finite, and the range that underflows
							case ($urandom_range(0, 4))
								0:       w[30:23] = 8'h00;
								1:       w[30:23] = 8'h01;
								2:       w[30:23] = 8'hFF;
								3:       w[30:23] = 8'hFE;
								default: w[30:23] = 8'($urandom_range(0, 12));
							endcase
						end else begin
							case ($urandom_range(0, 3))
								0:       v = fsign;
								1:       v = fsign - 32'd1;
								2:       v = fmask;
								default: v = fsign + 32'd1;
							endcase
							w = (w & ~fmask) | v;
						end
					end
					1: begin
						// tiny magnitudes: rounding around zero
						v = $urandom_range(0, 4);
						w = $urandom_range(0, 1) ? (~v + 32'd1) : v;
					end
					default: ;
				endcase
				queue_sample(w, $urandom_range(0, 7) == 0);
			end
			random_items += n;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && scaled_expect.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hang guard: the slowest correct run is well under a tenth of this
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
